// ===== rtl/core/otp_pkg.sv =====
// ----------------------------------------------------------------------------
// OTP token generator package
// Shared types, constants, and AES and CRC helper functions.
// ----------------------------------------------------------------------------
package otp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PRIV_ID  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_BOOT_CNT = 2'd3;

  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  CNT_LAST  = 8'd255;

  // Work item handed from the front end to the AES engine.
  typedef struct packed {
    logic         refused;
    logic [127:0] plaintext;
    logic [127:0] key;
  } otp_job_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] gmul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One CRC byte step: eight shifts of the reflected polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/otp_front.sv =====
// ----------------------------------------------------------------------------
// OTP front end
// Accepts requests, builds the plaintext with its check bytes, with the CRC
// split around a stage register, and pushes a job into the queue.
// ----------------------------------------------------------------------------
module otp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [15:0]       random_pair,
  input  logic [127:0]      key,
  input  logic [47:0]       device_id,
  input  logic [15:0]       boot_number,
  output logic              job_valid,
  input  logic              job_ready,
  output otp_pkg::otp_job_t job
);

  logic [7:0]   token_counter;
  logic         s1_valid;
  logic         s1_refused;
  logic [111:0] s1_bytes;
  logic [15:0]  s1_crc;
  logic [127:0] s1_key;
  logic [15:0]  crc_mid;
  logic [111:0] bytes_in;
  logic [15:0]  crc_full;

  assign req_ready = !s1_valid || job_ready;
  assign job_valid = s1_valid;

  // First 14 plaintext bytes.
  assign bytes_in = {random_pair, token_counter, 16'h0000, token_counter,
                     boot_number, device_id};

  // First half of the CRC: seven bytes per cycle.
  always_comb begin
    crc_mid = otp_pkg::CRC_INIT;
    for (int i = 0; i < 7; i++) begin
      crc_mid = otp_pkg::crc_byte(crc_mid, bytes_in[8*i +: 8]);
    end
  end

  // Second half of the CRC in the stage register cycle.
  always_comb begin
    crc_full = s1_crc;
    for (int i = 7; i < 14; i++) begin
      crc_full = otp_pkg::crc_byte(crc_full, s1_bytes[8*i +: 8]);
    end
  end

  assign job.refused   = s1_refused;
  assign job.plaintext = {~crc_full, s1_bytes};
  assign job.key       = s1_key;

  // Stage register and token counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      token_counter <= '0;
    end else begin
      if (req_valid && req_ready) begin
        s1_valid <= 1'b1;
        if (token_counter != otp_pkg::CNT_LAST) begin
          token_counter <= token_counter + 8'd1;
        end
      end else if (job_ready) begin
        s1_valid <= 1'b0;
      end
    end
    if (req_valid && req_ready) begin
      s1_refused <= (token_counter == otp_pkg::CNT_LAST);
      s1_bytes   <= bytes_in;
      s1_crc     <= crc_mid;
      s1_key     <= key;
    end
  end

  // The counter never wraps back to zero.
  assert property (@(posedge clk) disable iff (rst)
    $past(token_counter) == otp_pkg::CNT_LAST |-> token_counter == otp_pkg::CNT_LAST)
    else $error("token counter wrapped");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !job_ready |=> s1_valid && $stable(s1_bytes))
    else $error("stage lost a job");
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && token_counter != otp_pkg::CNT_LAST
    |=> token_counter == $past(token_counter) + 8'd1)
    else $error("counter did not advance");

endmodule

// ===== rtl/core/otp_queue.sv =====
// ----------------------------------------------------------------------------
// OTP job queue
// Two-entry queue between the front end and the AES engine.
// ----------------------------------------------------------------------------
module otp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  otp_pkg::otp_job_t in_job,
  output logic              out_valid,
  input  logic              out_ready,
  output otp_pkg::otp_job_t out_job
);

  otp_pkg::otp_job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wr_ptr] <= in_job;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count wrong");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers diverged");

endmodule

// ===== rtl/core/otp_aes.sv =====
// ----------------------------------------------------------------------------
// OTP AES engine
// Iterative AES-128: one round and one key-schedule step per cycle, with an
// output register toward the result channel.
// ----------------------------------------------------------------------------
module otp_aes (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  otp_pkg::otp_job_t job,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [127:0]      res_data,
  output logic              res_refused
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t       state;
  logic [3:0]   round;
  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0]   rcon;
  logic         job_refused;
  logic [127:0] rk_next;
  logic [127:0] st_next;
  logic [127:0] sb;
  logic [127:0] mc;
  logic         out_free;

  assign out_free  = !res_valid || res_ready;
  assign job_ready = (state == ST_IDLE);

  // Key schedule step.
  always_comb begin
    logic [31:0] w;
    w = {otp_pkg::sbox(rk[103:96]), otp_pkg::sbox(rk[127:120]),
         otp_pkg::sbox(rk[119:112]), otp_pkg::sbox(rk[111:104]) ^ rcon};
    rk_next[31:0]   = rk[31:0]   ^ w;
    rk_next[63:32]  = rk[63:32]  ^ rk_next[31:0];
    rk_next[95:64]  = rk[95:64]  ^ rk_next[63:32];
    rk_next[127:96] = rk[127:96] ^ rk_next[95:64];
  end

  // SubBytes and ShiftRows, then MixColumns (skipped in the last round) and AddRoundKey.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[8*(r+4*c) +: 8] = otp_pkg::sbox(st[8*(r+4*((c+r)%4)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sb[32*c +: 8];
      a1 = sb[32*c+8 +: 8];
      a2 = sb[32*c+16 +: 8];
      a3 = sb[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[32*c +: 8]    = a0 ^ al ^ otp_pkg::gmul2(a0 ^ a1);
      mc[32*c+8 +: 8]  = a1 ^ al ^ otp_pkg::gmul2(a1 ^ a2);
      mc[32*c+16 +: 8] = a2 ^ al ^ otp_pkg::gmul2(a2 ^ a3);
      mc[32*c+24 +: 8] = a3 ^ al ^ otp_pkg::gmul2(a3 ^ a0);
    end
    st_next = ((round == 4'd10) ? sb : mc) ^ rk_next;
  end

  // Round sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // The result register fills from the done state and drains on accept.
      if (state == ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            if (job.refused) begin
              st          <= '0;
              job_refused <= 1'b1;
              state       <= ST_DONE;
            end else begin
              st          <= job.plaintext ^ job.key;
              rk          <= job.key;
              rcon        <= 8'h01;
              round       <= 4'd1;
              job_refused <= 1'b0;
              state       <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          st    <= st_next;
          rk    <= rk_next;
          rcon  <= otp_pkg::gmul2(rcon);
          round <= round + 4'd1;
          if (round == 4'd10) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            res_data    <= st;
            res_refused <= job_refused;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> round >= 4'd1 && round <= 4'd10)
    else $error("round out of range");
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data) && $stable(res_refused))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && round == 4'd10 |=> state == ST_DONE)
    else $error("round count broken");

endmodule

// ===== rtl/core/otp_token_generator.sv =====
// ----------------------------------------------------------------------------
// OTP token generator
// AES-128 one-time-password token generator with CRC-16 check bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_axis channel carries two random bytes. The block
//   answers every item with exactly one item on m_axis: the 128-bit
//   ciphertext and a refused flag in tuser. Once 255 tokens have been made,
//   later requests are refused with a zero token. Configuration is written
//   by cfg_valid/cfg_ready and cfg_index (0 key low, 1 key high, 2 private
//   id, 3 boot count); the user must do this only while idle (unenforced).
// Structure:
//   The front end builds the plaintext and CRC around its stage register,
//   then a two-entry queue feeds the iterative AES engine, which loads a
//   job, runs ten rounds and writes the output register. The engine takes
//   a new job only when idle, after its last result has moved to the output
//   register; refused items skip the rounds.
// Reset clears the counter, the keys and id to zero and the boot count to
// one. A stalled receiver holds the result; the queue then fills and
// s_axis_tready falls.
// ----------------------------------------------------------------------------
module otp_token_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // random_pair
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // token_low, token_high
  output logic         m_axis_tuser,   // refused
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0]       key_low;
  logic [63:0]       key_high;
  logic [47:0]       device_id;
  logic [15:0]       boot_number;
  logic              f_valid;
  logic              f_ready;
  otp_pkg::otp_job_t f_job;
  logic              q_valid;
  logic              q_ready;
  otp_pkg::otp_job_t q_job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      device_id   <= '0;
      boot_number <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        otp_pkg::REG_KEY_LOW:  key_low     <= cfg_data;
        otp_pkg::REG_KEY_HIGH: key_high    <= cfg_data;
        otp_pkg::REG_PRIV_ID:  device_id   <= cfg_data[47:0];
        otp_pkg::REG_BOOT_CNT: boot_number <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  otp_front u_front (
    .clk, .rst,
    .req_valid   (s_axis_tvalid),
    .req_ready   (s_axis_tready),
    .random_pair (s_axis_tdata),
    .key         ({key_high, key_low}),
    .device_id,
    .boot_number,
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job         (f_job)
  );

  otp_queue u_queue (
    .clk, .rst,
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_job   (q_job)
  );

  otp_aes u_aes (
    .clk, .rst,
    .job_valid   (q_valid),
    .job_ready   (q_ready),
    .job         (q_job),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res_data    (m_axis_tdata),
    .res_refused (m_axis_tuser)
  );

endmodule
